>>> rtl/rlss_pkg.sv
// shared types and constants of the rgb led strip serializer
package rlss_pkg;

  localparam int LED_COUNT_DEF = 64;
  localparam int ADDR_W        = 10;
  localparam int COLOR_W       = 24;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0]  ONE_HIGH_RST  = 8'd19;
  localparam logic [7:0]  ZERO_HIGH_RST = 8'd11;
  localparam logic [7:0]  PERIOD_RST    = 8'd30;
  localparam logic [15:0] RESET_LOW_RST = 16'd1200;

  localparam logic [1:0] REG_ONE_HIGH  = 2'd0;
  localparam logic [1:0] REG_ZERO_HIGH = 2'd1;
  localparam logic [1:0] REG_PERIOD    = 2'd2;
  localparam logic [1:0] REG_RESET_LOW = 2'd3;

  localparam logic [2:0] ACT_TICK      = 3'd0;
  localparam logic [2:0] ACT_SET       = 3'd1;
  localparam logic [2:0] ACT_CLEAR     = 3'd2;
  localparam logic [2:0] ACT_CLEAR_ALL = 3'd3;
  localparam logic [2:0] ACT_REFRESH   = 3'd4;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_SET,
    CMD_CLEAR,
    CMD_CLEAR_ALL,
    CMD_REFRESH,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [ADDR_W-1:0]   addr;
    logic [COLOR_W-1:0]  color;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  one_high;
    logic [7:0]  zero_high;
    logic [7:0]  period;
    logic [15:0] reset_low;
  } cfg_t;

endpackage

>>> rtl/rgb_led_strip_serializer_top.sv
// top level of the rgb led strip serializer with apb register port
// Each input word is one tick of line timing and may carry a pixel or refresh
// command; every word yields exactly one result word (line level, busy,
// rejected). Words are taken one per cycle unless results back up: a two-entry
// command queue sits between the decoder and the line engine, and a result
// register holds each result until it is taken. A refresh holds the line low
// for reset_low words, then sends LED_COUNT pixels as 24 bits each, green, red,
// blue, msb first, period words per bit. The pixel store has one write and one
// read port and is read one pixel ahead; per-entry valid flags clear it at
// reset or on clear all, so no clearing pass is needed.
module rgb_led_strip_serializer_top #(
  parameter int LED_COUNT = rlss_pkg::LED_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  action,
  input  logic [rlss_pkg::ADDR_W-1:0] led_index,
  input  logic [7:0]                  red,
  input  logic [7:0]                  green,
  input  logic [7:0]                  blue,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        data_line,
  output logic                        busy_res,
  output logic                        rejected
);

  rlss_pkg::cfg_t cfg;
  rlss_pkg::cmd_t push_data;
  rlss_pkg::cmd_t pop_data;
  logic           push_valid;
  logic           push_ready;
  logic           pop_valid;
  logic           pop_ready;
  logic           cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.one_high  <= rlss_pkg::ONE_HIGH_RST;
      cfg.zero_high <= rlss_pkg::ZERO_HIGH_RST;
      cfg.period    <= rlss_pkg::PERIOD_RST;
      cfg.reset_low <= rlss_pkg::RESET_LOW_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        rlss_pkg::REG_ONE_HIGH:  cfg.one_high  <= pwdata[7:0];
        rlss_pkg::REG_ZERO_HIGH: cfg.zero_high <= pwdata[7:0];
        rlss_pkg::REG_PERIOD:    cfg.period    <= pwdata[7:0];
        rlss_pkg::REG_RESET_LOW: cfg.reset_low <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      rlss_pkg::REG_ONE_HIGH:  prdata = {24'd0, cfg.one_high};
      rlss_pkg::REG_ZERO_HIGH: prdata = {24'd0, cfg.zero_high};
      rlss_pkg::REG_PERIOD:    prdata = {24'd0, cfg.period};
      rlss_pkg::REG_RESET_LOW: prdata = {16'd0, cfg.reset_low};
      default:                 prdata = '0;
    endcase
  end

  rlss_front #(
    .LED_COUNT(LED_COUNT)
  ) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .led_index (led_index),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  rlss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  rlss_back #(
    .LED_COUNT(LED_COUNT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (pop_valid),
    .q_ready  (pop_ready),
    .q_data   (pop_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .data_line(data_line),
    .busy_res (busy_res),
    .rejected (rejected)
  );

endmodule

>>> rtl/rlss_front.sv
// front end: decodes each input word into a command for the queue
module rlss_front #(
  parameter int LED_COUNT = rlss_pkg::LED_COUNT_DEF
) (
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      action,
  input  logic [rlss_pkg::ADDR_W-1:0]     led_index,
  input  logic [7:0]                      red,
  input  logic [7:0]                      green,
  input  logic [7:0]                      blue,
  output logic                            push_valid,
  input  logic                            push_ready,
  output rlss_pkg::cmd_t                  push_data
);

  logic idx_ok;

  assign idx_ok = (led_index != '0) &&
                  ({1'b0, led_index} <= (rlss_pkg::ADDR_W + 1)'(LED_COUNT));

  always_comb begin
    push_data.addr  = led_index - (rlss_pkg::ADDR_W)'(1);
    // stored in line order: green, red, blue
    push_data.color = {green, red, blue};
    case (action)
      rlss_pkg::ACT_TICK:      push_data.kind = rlss_pkg::CMD_TICK;
      rlss_pkg::ACT_SET:       push_data.kind = idx_ok ? rlss_pkg::CMD_SET : rlss_pkg::CMD_BAD;
      rlss_pkg::ACT_CLEAR:     push_data.kind = idx_ok ? rlss_pkg::CMD_CLEAR : rlss_pkg::CMD_BAD;
      rlss_pkg::ACT_CLEAR_ALL: push_data.kind = rlss_pkg::CMD_CLEAR_ALL;
      rlss_pkg::ACT_REFRESH:   push_data.kind = rlss_pkg::CMD_REFRESH;
      default:                 push_data.kind = rlss_pkg::CMD_BAD;
    endcase
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

>>> rtl/rlss_queue.sv
// short command queue between front end and line engine
module rlss_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  rlss_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rlss_pkg::cmd_t pop_data
);

  localparam int PW = (rlss_pkg::QUEUE_DEPTH > 1) ? $clog2(rlss_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(rlss_pkg::QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(rlss_pkg::QUEUE_DEPTH - 1);

  rlss_pkg::cmd_t slots [rlss_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  assign push_ready = count != CW'(rlss_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == LAST) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

>>> rtl/rlss_back.sv
// line engine: pixel store, reset and bit timing, result register
module rlss_back #(
  parameter int LED_COUNT = rlss_pkg::LED_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  rlss_pkg::cfg_t cfg,
  input  logic           q_valid,
  output logic           q_ready,
  input  rlss_pkg::cmd_t q_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           data_line,
  output logic           busy_res,
  output logic           rejected
);

  localparam int IW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int LW = $clog2(LED_COUNT + 1);
  localparam logic [LW-1:0] LAST_LED = LW'(LED_COUNT - 1);
  localparam logic [4:0]    LAST_BIT = 5'd23;

  typedef enum logic [1:0] {PH_IDLE, PH_RESET, PH_SEND} phase_t;

  phase_t                        phase;
  phase_t                        phase_next;
  logic [15:0]                   tick_count;
  logic [15:0]                   tick_next;
  logic [4:0]                    bit_count;
  logic [4:0]                    bit_next;
  logic [LW-1:0]                 led_count;
  logic [LW-1:0]                 led_next;
  logic [rlss_pkg::COLOR_W-1:0]  shift_word;
  logic [rlss_pkg::COLOR_W-1:0]  shift_next;
  logic                          fresh;
  logic                          fresh_next;
  logic [LED_COUNT-1:0]          valid;

  logic [rlss_pkg::COLOR_W-1:0]  mem [LED_COUNT];
  logic [rlss_pkg::COLOR_W-1:0]  rd_mem;
  logic                          rd_ok;

  logic                          fire;
  logic                          busy;
  logic                          start;
  logic                          do_write;
  logic                          do_clear;
  logic                          rej;
  logic                          line;
  logic                          busy_o;
  phase_t                        ph;
  logic [15:0]                   tc1;
  logic [rlss_pkg::COLOR_W-1:0]  eff;
  logic [7:0]                    high;
  logic                          end_bit;
  logic [LW-1:0]                 led_inc;
  logic [IW-1:0]                 rd_addr;
  logic [IW-1:0]                 wr_addr;
  logic [rlss_pkg::COLOR_W-1:0]  wr_data;

  assign q_ready = !out_valid || out_ready;
  assign fire    = q_valid && q_ready;
  assign busy    = phase != PH_IDLE;
  assign led_inc = led_count + LW'(1);
  assign rd_addr = (phase == PH_SEND && led_count != LAST_LED) ? led_inc[IW-1:0] : '0;
  assign wr_addr = q_data.addr[IW-1:0];
  assign wr_data = (q_data.kind == rlss_pkg::CMD_SET) ? q_data.color : '0;
  assign eff     = fresh ? (rd_ok ? rd_mem : '0) : shift_word;
  assign high    = eff[rlss_pkg::COLOR_W-1] ? cfg.one_high : cfg.zero_high;
  assign end_bit = ({1'b0, tick_count} + 17'd1) >= {9'd0, cfg.period};

  always_comb begin
    rej      = 1'b0;
    do_write = 1'b0;
    do_clear = 1'b0;
    start    = 1'b0;
    case (q_data.kind)
      rlss_pkg::CMD_TICK: begin
      end
      rlss_pkg::CMD_SET, rlss_pkg::CMD_CLEAR: begin
        rej      = busy;
        do_write = !busy;
      end
      rlss_pkg::CMD_CLEAR_ALL: begin
        rej      = busy;
        do_clear = !busy;
        start    = !busy;
      end
      rlss_pkg::CMD_REFRESH: begin
        rej   = busy;
        start = !busy;
      end
      default: rej = 1'b1;
    endcase
  end

  always_comb begin
    ph         = start ? PH_RESET : phase;
    phase_next = ph;
    tick_next  = start ? '0 : tick_count;
    bit_next   = start ? '0 : bit_count;
    led_next   = start ? '0 : led_count;
    shift_next = shift_word;
    fresh_next = fresh;
    tc1        = tick_next + 16'd1;
    line       = 1'b0;
    busy_o     = 1'b0;
    case (ph)
      PH_RESET: begin
        busy_o = 1'b1;
        if (tc1 == '0 || tc1 >= cfg.reset_low) begin
          phase_next = PH_SEND;
          tick_next  = '0;
          bit_next   = '0;
          led_next   = '0;
          fresh_next = 1'b1;
        end else begin
          tick_next = tc1;
        end
      end
      PH_SEND: begin
        busy_o     = 1'b1;
        line       = tick_count < {8'd0, high};
        fresh_next = 1'b0;
        if (end_bit) begin
          tick_next  = '0;
          shift_next = {eff[rlss_pkg::COLOR_W-2:0], 1'b0};
          if (bit_count == LAST_BIT) begin
            bit_next = '0;
            if (led_count == LAST_LED) begin
              led_next   = '0;
              shift_next = '0;
              phase_next = PH_IDLE;
            end else begin
              led_next   = led_inc;
              fresh_next = 1'b1;
            end
          end else begin
            bit_next = bit_count + 5'd1;
          end
        end else begin
          tick_next  = tick_count + 16'd1;
          shift_next = eff;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      bit_count  <= '0;
      led_count  <= '0;
      shift_word <= '0;
      fresh      <= 1'b0;
      valid      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (fire) begin
        phase      <= phase_next;
        tick_count <= tick_next;
        bit_count  <= bit_next;
        led_count  <= led_next;
        shift_word <= shift_next;
        fresh      <= fresh_next;
        data_line  <= line;
        busy_res   <= busy_o;
        rejected   <= rej;
        if (do_clear) begin
          valid <= '0;
        end else if (do_write) begin
          valid[wr_addr] <= 1'b1;
        end
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (do_write) begin
        mem[wr_addr] <= wr_data;
      end
      rd_mem <= mem[rd_addr];
      rd_ok  <= valid[rd_addr] && !do_clear;
    end
  end

  a_bit_range: assert property (@(posedge clk) disable iff (rst) bit_count <= LAST_BIT)
    else $error("bit counter out of range");

  a_led_range: assert property (@(posedge clk) disable iff (rst) led_count <= LAST_LED)
    else $error("led counter out of range");

  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> tick_count == '0)
    else $error("tick counter not cleared while idle");

  a_busy_reject: assert property (@(posedge clk) disable iff (rst)
    fire && busy && (q_data.kind == rlss_pkg::CMD_SET || q_data.kind == rlss_pkg::CMD_CLEAR)
    |=> out_valid && rejected && busy_res)
    else $error("pixel write during frame not rejected");

  a_clear_all: assert property (@(posedge clk) disable iff (rst)
    fire && do_clear |=> valid == '0 && phase != PH_IDLE)
    else $error("clear all did not empty the store or start a frame");

endmodule

>>> tb/rgb_led_strip_serializer_top_test.sv
// testbench for the rgb led strip serializer: directed table, timing extremes, random words
`timescale 1ns / 100ps

module rgb_led_strip_serializer_top_test;

  localparam int LEDS          = rlss_pkg::LED_COUNT_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int DIR_ROWS      = 21;
  localparam int PRINT_CAP     = 40;
  localparam int DRAIN_WORDS   = 16;

  localparam logic [2:0] ACT_RSVD5 = 3'd5;
  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;

  typedef enum logic [1:0] {LINE_IDLE, LINE_RESET, LINE_SEND} line_phase_t;

  typedef struct packed {
    logic data_line;
    logic busy;
    logic rejected;
  } line_res_t;

  localparam line_res_t RES_IDLE         = 3'b000;
  localparam line_res_t RES_REFUSED      = 3'b001;
  localparam line_res_t RES_LOW          = 3'b010;
  localparam line_res_t RES_BUSY_REFUSED = 3'b011;

  typedef struct packed {
    logic [2:0]  act;
    logic [9:0]  idx;
    logic [23:0] rgb;
    logic        typed;
    line_res_t   res;
    logic        drain;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  action = rlss_pkg::ACT_TICK;
  logic [rlss_pkg::ADDR_W-1:0] led_index = '0;
  logic [7:0]  red = '0;
  logic [7:0]  green = '0;
  logic [7:0]  blue = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        data_line;
  logic        busy_res;
  logic        rejected;

  rgb_led_strip_serializer_top dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .led_index(led_index), .red(red), .green(green), .blue(blue),
    .out_valid(out_valid), .out_ready(out_ready),
    .data_line(data_line), .busy_res(busy_res), .rejected(rejected)
  );

  always #5 clk = ~clk;

  // line model state
  logic [23:0]      pix_mem [LEDS];
  line_phase_t      strip_phase;
  logic [15:0]      tick_cnt;
  int               bit_cnt;
  int               led_cnt;
  logic [23:0]      shift_grb;
  rlss_pkg::cfg_t   strip_cfg;

  line_res_t ticks_in_flight [$];
  dir_row_t  dir_rows [DIR_ROWS];
  int        mismatch_cnt = 0;
  int        results_seen = 0;
  int        idle_cycles = 0;
  int        sink_hold = 0;
  int        gap_odds = 6;
  bit        sink_calm = 1'b0;

  task automatic flag_mismatch(input string msg);
    if (mismatch_cnt < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  function automatic logic [23:0] grb_of(input int n);
    logic [23:0] px;
    px = pix_mem[n];
    return {px[15:8], px[23:16], px[7:0]};
  endfunction

  function automatic line_res_t strip_tick(input logic [2:0] a, input logic [9:0] idx,
                                           input logic [23:0] rgb);
    line_res_t res;
    logic      idx_ok;
    logic [7:0] high;
    res = RES_IDLE;
    idx_ok = idx >= 10'd1 && idx <= LEDS;
    if (a == rlss_pkg::ACT_TICK) begin
      res.rejected = 1'b0;
    end else if (a > rlss_pkg::ACT_REFRESH || strip_phase != LINE_IDLE) begin
      res.rejected = 1'b1;
    end else if (a == rlss_pkg::ACT_SET || a == rlss_pkg::ACT_CLEAR) begin
      if (!idx_ok) res.rejected = 1'b1;
      else pix_mem[idx - 10'd1] = (a == rlss_pkg::ACT_SET) ? rgb : 24'd0;
    end else begin
      if (a == rlss_pkg::ACT_CLEAR_ALL)
        for (int i = 0; i < LEDS; i++) pix_mem[i] = '0;
      strip_phase = LINE_RESET;
      tick_cnt = '0;
      bit_cnt = 0;
      led_cnt = 0;
    end
    case (strip_phase)
      LINE_RESET: begin
        res.busy = 1'b1;
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt == 16'd0 || tick_cnt >= strip_cfg.reset_low) begin
          strip_phase = LINE_SEND;
          tick_cnt = '0;
          bit_cnt = 0;
          led_cnt = 0;
          shift_grb = grb_of(0);
        end
      end
      LINE_SEND: begin
        high = shift_grb[23] ? strip_cfg.one_high : strip_cfg.zero_high;
        res.data_line = tick_cnt < high;
        res.busy = 1'b1;
        if (int'(tick_cnt) + 1 >= int'(strip_cfg.period)) begin
          tick_cnt = '0;
          shift_grb = {shift_grb[22:0], 1'b0};
          bit_cnt++;
          if (bit_cnt >= 24) begin
            bit_cnt = 0;
            led_cnt++;
            if (led_cnt >= LEDS) begin
              led_cnt = 0;
              shift_grb = '0;
              strip_phase = LINE_IDLE;
            end else begin
              shift_grb = grb_of(led_cnt);
            end
          end
        end else begin
          tick_cnt = tick_cnt + 16'd1;
        end
      end
      default: res.busy = 1'b0;
    endcase
    return res;
  endfunction

  task automatic push_tick(input logic [2:0] a, input logic [9:0] idx, input logic [23:0] rgb,
                           input logic typed, input line_res_t typed_res);
    int        gap;
    line_res_t guess;
    gap = 0;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= a;
    led_index <= idx;
    red <= rgb[23:16];
    green <= rgb[15:8];
    blue <= rgb[7:0];
    do @(posedge clk); while (!in_ready);
    guess = strip_tick(a, idx, rgb);
    ticks_in_flight.push_back(typed ? typed_res : guess);
  endtask

  task automatic send_word(input logic [2:0] a, input logic [9:0] idx, input logic [23:0] rgb);
    push_tick(a, idx, rgb, 1'b0, RES_IDLE);
  endtask

  // tick words while the frame runs, with an odd command thrown in
  task automatic drain_frame(input int words);
    for (int n = 0; n < words && strip_phase != LINE_IDLE; n++) begin
      if ($urandom_range(0, 63) == 0)
        send_word(3'(rlss_pkg::ACT_SET + $urandom_range(0, 6)), 10'($urandom()),
                  24'($urandom()));
      else
        send_word(rlss_pkg::ACT_TICK, 10'($urandom()), 24'($urandom()));
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      rlss_pkg::REG_ONE_HIGH:  strip_cfg.one_high = val[7:0];
      rlss_pkg::REG_ZERO_HIGH: strip_cfg.zero_high = val[7:0];
      rlss_pkg::REG_PERIOD:    strip_cfg.period = val[7:0];
      rlss_pkg::REG_RESET_LOW: strip_cfg.reset_low = val[15:0];
      default: ;
    endcase
    // read back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== val)
      flag_mismatch($sformatf("register %0d reads %h, want %h", idx, prdata, val));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_timing(input logic [7:0] one, input logic [7:0] zero,
                             input logic [7:0] period, input logic [15:0] low);
    in_valid <= 1'b0;
    do @(posedge clk); while (ticks_in_flight.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(rlss_pkg::REG_ONE_HIGH, {24'd0, one});
    write_reg(rlss_pkg::REG_ZERO_HIGH, {24'd0, zero});
    write_reg(rlss_pkg::REG_PERIOD, {24'd0, period});
    write_reg(rlss_pkg::REG_RESET_LOW, {16'd0, low});
  endtask

  task automatic random_phase(input int words);
    int pick;
    repeat (words) begin
      if ($urandom_range(0, 49) == 0) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (ticks_in_flight.size() != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 40)
        send_word(rlss_pkg::ACT_SET, 10'($urandom_range(1, LEDS)), 24'($urandom()));
      else if (pick < 50)
        send_word(rlss_pkg::ACT_CLEAR, 10'($urandom_range(1, LEDS)), 24'($urandom()));
      else if (pick < 58)
        send_word($urandom_range(0, 1) ? rlss_pkg::ACT_SET : rlss_pkg::ACT_CLEAR,
                  $urandom_range(0, 1) ? 10'd0 : 10'($urandom_range(LEDS + 1, 1023)),
                  24'($urandom()));
      else if (pick < 63)
        send_word(3'(ACT_RSVD5 + $urandom_range(0, 2)), 10'($urandom()), 24'($urandom()));
      else if (pick < 95)
        send_word(rlss_pkg::ACT_TICK, 10'($urandom()), 24'($urandom()));
      else
        send_word(pick < 96 ? rlss_pkg::ACT_CLEAR_ALL : rlss_pkg::ACT_REFRESH,
                  10'($urandom()), 24'($urandom()));
    end
  endtask

  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else if (sink_calm || $urandom_range(0, 3) != 0) begin
      out_ready <= 1'b1;
      sink_hold <= $urandom_range(0, 24);
    end else begin
      out_ready <= 1'b0;
      sink_hold <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin : check_results
    line_res_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (ticks_in_flight.size() == 0) begin
        flag_mismatch($sformatf("word %0d arrived with nothing pending", results_seen));
      end else begin
        want = ticks_in_flight.pop_front();
        if (data_line !== want.data_line)
          flag_mismatch($sformatf("word %0d data_line %b, want %b",
                                  results_seen, data_line, want.data_line));
        if (busy_res !== want.busy)
          flag_mismatch($sformatf("word %0d busy_res %b, want %b",
                                  results_seen, busy_res, want.busy));
        if (rejected !== want.rejected)
          flag_mismatch($sformatf("word %0d rejected %b, want %b",
                                  results_seen, rejected, want.rejected));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int p;
    for (int i = 0; i < LEDS; i++) pix_mem[i] = '0;
    strip_phase = LINE_IDLE;
    tick_cnt = '0;
    bit_cnt = 0;
    led_cnt = 0;
    shift_grb = '0;
    strip_cfg = {rlss_pkg::ONE_HIGH_RST, rlss_pkg::ZERO_HIGH_RST, rlss_pkg::PERIOD_RST,
                 rlss_pkg::RESET_LOW_RST};

    dir_rows[0]  = {rlss_pkg::ACT_TICK,      10'd0,    24'h000000, 1'b1, RES_IDLE,    1'b0};
    dir_rows[1]  = {rlss_pkg::ACT_TICK,      10'd1023, 24'hffffff, 1'b1, RES_IDLE,    1'b0};
    dir_rows[2]  = {rlss_pkg::ACT_SET,       10'd1,    24'h00ff00, 1'b1, RES_IDLE,    1'b0};
    dir_rows[3]  = {rlss_pkg::ACT_SET,       10'd64,   24'h00ff00, 1'b0, RES_IDLE,    1'b0};
    dir_rows[4]  = {rlss_pkg::ACT_SET,       10'd2,    24'h0000ff, 1'b0, RES_IDLE,    1'b0};
    dir_rows[5]  = {rlss_pkg::ACT_SET,       10'd3,    24'hffffff, 1'b0, RES_IDLE,    1'b0};
    dir_rows[6]  = {rlss_pkg::ACT_SET,       10'd0,    24'hffffff, 1'b1, RES_REFUSED, 1'b0};
    dir_rows[7]  = {rlss_pkg::ACT_SET,       10'd65,   24'h123456, 1'b1, RES_REFUSED, 1'b0};
    dir_rows[8]  = {rlss_pkg::ACT_CLEAR,     10'd1023, 24'h000000, 1'b1, RES_REFUSED, 1'b0};
    dir_rows[9]  = {rlss_pkg::ACT_CLEAR,     10'd3,    24'h000000, 1'b0, RES_IDLE,    1'b0};
    dir_rows[10] = {rlss_pkg::ACT_SET,       10'd4,    24'ha55a3c, 1'b0, RES_IDLE,    1'b0};
    dir_rows[11] = {ACT_RSVD5,               10'd1,    24'hffffff, 1'b1, RES_REFUSED, 1'b0};
    dir_rows[12] = {ACT_RSVD6,               10'd64,   24'h000000, 1'b1, RES_REFUSED, 1'b0};
    dir_rows[13] = {ACT_RSVD7,               10'd0,    24'h555555, 1'b1, RES_REFUSED, 1'b0};
    dir_rows[14] = {rlss_pkg::ACT_SET,       10'd63,   24'hc3c3c3, 1'b0, RES_IDLE,    1'b0};
    dir_rows[15] = {rlss_pkg::ACT_CLEAR,     10'd64,   24'h000000, 1'b0, RES_IDLE,    1'b0};
    dir_rows[16] = {rlss_pkg::ACT_REFRESH,   10'd0,    24'h000000, 1'b1, RES_LOW,     1'b0};
    dir_rows[17] = {rlss_pkg::ACT_SET,       10'd5,    24'hffffff, 1'b1, RES_BUSY_REFUSED,
                    1'b0};
    dir_rows[18] = {rlss_pkg::ACT_CLEAR,     10'd1,    24'h000000, 1'b1, RES_BUSY_REFUSED,
                    1'b0};
    dir_rows[19] = {rlss_pkg::ACT_CLEAR_ALL, 10'd0,    24'h000000, 1'b1, RES_BUSY_REFUSED,
                    1'b0};
    dir_rows[20] = {rlss_pkg::ACT_REFRESH,   10'd0,    24'h000000, 1'b1, RES_BUSY_REFUSED,
                    1'b1};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset timing, pixel commands, then a frame started
    for (int i = 0; i < DIR_ROWS; i++) begin
      push_tick(dir_rows[i].act, dir_rows[i].idx, dir_rows[i].rgb,
                dir_rows[i].typed, dir_rows[i].res);
      if (dir_rows[i].drain) drain_frame(DRAIN_WORDS);
    end

    // widest bit period, one bits held high the whole period
    load_timing(8'd255, 8'd1, 8'd255, 16'd1);
    gap_odds = 0;
    sink_calm = 1'b1;
    send_word(rlss_pkg::ACT_REFRESH, 10'($urandom()), 24'($urandom()));
    drain_frame(40);
    gap_odds = 6;
    sink_calm = 1'b0;

    // short bit period, zero bits held high the whole period
    load_timing(8'd1, 8'd255, 8'd2, 16'hffff);
    send_word(rlss_pkg::ACT_SET, 10'd7, 24'h123456);
    send_word(rlss_pkg::ACT_CLEAR_ALL, 10'($urandom()), 24'($urandom()));
    drain_frame(60);

    // zero reset low and one-tick bit period
    load_timing(8'd1, 8'd1, 8'd1, 16'd0);
    send_word(rlss_pkg::ACT_SET, 10'(LEDS), 24'($urandom()));
    send_word(rlss_pkg::ACT_SET, 10'd1, 24'($urandom()));
    send_word(rlss_pkg::ACT_REFRESH, 10'($urandom()), 24'($urandom()));
    drain_frame(80);

    repeat (3) begin
      p = $urandom_range(2, 4);
      load_timing(8'($urandom_range(1, p + 1)), 8'($urandom_range(1, p)), 8'(p),
                  16'($urandom_range(1, 40)));
      random_phase(70);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (ticks_in_flight.size() != 0);
    repeat (SETTLE_CYCLES * 3) @(posedge clk);
    if (mismatch_cnt == 0 && ticks_in_flight.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/rlss_pkg.sv
rtl/rlss_front.sv
rtl/rlss_queue.sv
rtl/rlss_back.sv
rtl/rgb_led_strip_serializer_top.sv
tb/rgb_led_strip_serializer_top_test.sv
